// File: design/sfd_pkg.sv
// Shared types and constants of the serial frame deframer.
// No dependencies; serial_frame_deframer.sv and the sim files refer to it by scoped names.
package sfd_pkg;

	// Frame phases
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_COUNT  = 2'd1,
		PH_DATA   = 2'd2,
		PH_WAIT   = 2'd3
	} phase_t;

	// Register map: index of each register, at byte address 4 * index
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_HDR_PATTERN = 2'd0;
	localparam logic [1:0] REG_HDR_MASK    = 2'd1;
	localparam logic [1:0] REG_CH_TOTAL    = 2'd2;

	// Reset values of the registers
	localparam logic [31:0] HDR_PATTERN_RST = 32'h0000_0000;
	localparam logic [31:0] HDR_MASK_RST    = 32'hFFFF_FFFF;
	localparam logic [7:0]  CH_TOTAL_RST    = 8'd1;

	// Framing geometry
	localparam logic [4:0]  COUNT_BITS  = 5'd30;       // bits read after the header
	localparam logic [4:0]  SLOT_BITS   = 5'd21;       // bits per channel slot
	localparam int unsigned COUNT_SHIFT = 10;          // queue shift after the count word
	localparam int unsigned SLOT_TOP    = 21;          // entry bit of a channel slot
	localparam logic [31:0] HI_BYTE_MASK = 32'h0003_FC00; // window bits 17..10

endpackage

// File: design/sfd_if.sv
// Handshake channels of the serial frame deframer: line samples in, channel words out.
// Depends on nothing; valid/ready transfer one transaction per accepting edge.
interface sfd_bit_if;
	logic valid;
	logic ready;
	logic line_bit;
	logic release_done;

	modport source (output valid, output line_bit, output release_done, input ready);
	modport sink   (input valid, input line_bit, input release_done, output ready);
endinterface

interface sfd_word_if;
	logic        valid;
	logic        ready;
	logic [7:0]  channel_index;
	logic [15:0] channel_value;
	logic [7:0]  frame_count_field;
	logic        last_channel;

	modport source (output valid, output channel_index, output channel_value,
		output frame_count_field, output last_channel, input ready);
	modport sink   (input valid, input channel_index, input channel_value,
		input frame_count_field, input last_channel, output ready);
endinterface

// File: design/serial_frame_deframer.sv
// Serial frame deframer: hunts a header in a bit-serial line, reads a count word and
// cuts the following channel slots into 16-bit words.
// Depends on sfd_pkg and the channel interfaces in sfd_if.sv.
//
// Usage:
//  - samples carries one sampled line bit per transaction, with release_done, which
//    clears the frame done flag so that the block hunts for the next header.
//  - channels carries one word per completed 21-bit slot: its index in the frame, the
//    value (window bits 17..10 over bits 7..0), the captured count byte and a flag on
//    the last channel of the frame.
//  - The APB port sets the header pattern (0x0), header mask (0x4) and channels per
//    frame (0x8); write them only while the block is idle. pready is tied high.
// Timing: one sample is taken per cycle unless a stall holds it. A channel word is registered
// and shows on channels in the cycle after the sample that completes its slot; the sample logic is a
// single shift, compare and count step between the state and output registers.
// Stall: while a word waits in the output register, samples that complete no slot are
// still taken; only a sample that would complete a slot waits for the word to leave.
// Reset: state clears to header hunt with an empty queue, registers take their reset
// values and the output register empties.
module serial_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	sfd_bit_if.sink                       samples,
	sfd_word_if.source                    channels,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfd_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// Configuration registers
	logic [31:0] hdr_pattern_q;
	logic [31:0] hdr_mask_q;
	logic [7:0]  ch_total_q;

	// Framing state
	sfd_pkg::phase_t phase_q, phase_d;
	logic [31:0] queue_q, queue_d;
	logic [4:0]  bit_cnt_q, bit_cnt_d;
	logic [7:0]  ch_cnt_q, ch_cnt_d;
	logic        done_q, done_d;
	logic [7:0]  cap_cnt_q, cap_cnt_d;

	// Output register
	logic        out_valid_q;
	logic [7:0]  out_index_q;
	logic [15:0] out_value_q;
	logic [7:0]  out_count_q;
	logic        out_last_q;

	// Step logic
	logic        accept;
	logic        slot_end;
	logic        emit;
	logic [15:0] res_value;
	logic        res_last;
	logic [31:0] shift_hdr;
	logic [31:0] shift_slot;
	logic [31:0] slot_masked;
	logic [4:0]  bit_cnt_dec;
	logic [7:0]  ch_cnt_inc;
	logic        cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pattern_q <= sfd_pkg::HDR_PATTERN_RST;
			hdr_mask_q    <= sfd_pkg::HDR_MASK_RST;
			ch_total_q    <= sfd_pkg::CH_TOTAL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				sfd_pkg::REG_HDR_PATTERN: hdr_pattern_q <= pwdata;
				sfd_pkg::REG_HDR_MASK:    hdr_mask_q    <= pwdata;
				sfd_pkg::REG_CH_TOTAL:    ch_total_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			sfd_pkg::REG_HDR_PATTERN: prdata = hdr_pattern_q;
			sfd_pkg::REG_HDR_MASK:    prdata = hdr_mask_q;
			sfd_pkg::REG_CH_TOTAL:    prdata = {24'd0, ch_total_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// A slot completes on this sample; only then is the output register needed
	assign slot_end = (phase_q == sfd_pkg::PH_DATA) && (bit_cnt_q == 5'd1);
	assign samples.ready = !slot_end || !out_valid_q || channels.ready;
	assign accept = samples.valid && samples.ready;

	assign shift_hdr   = {samples.line_bit, queue_q[31:1]};
	assign shift_slot  = (queue_q >> 1) | (32'(samples.line_bit) << sfd_pkg::SLOT_TOP);
	assign slot_masked = shift_slot & sfd_pkg::HI_BYTE_MASK;
	assign bit_cnt_dec = bit_cnt_q - 5'd1;
	assign ch_cnt_inc  = ch_cnt_q + 8'd1;

	// Next state and result of one sample
	always_comb begin
		phase_d   = phase_q;
		queue_d   = queue_q;
		bit_cnt_d = bit_cnt_q;
		ch_cnt_d  = ch_cnt_q;
		cap_cnt_d = cap_cnt_q;
		done_d    = samples.release_done ? 1'b0 : done_q;
		emit      = 1'b0;
		res_value = {slot_masked[17:10], shift_slot[7:0]};
		res_last  = 1'b0;
		unique case (phase_q)
			sfd_pkg::PH_HEADER: begin
				queue_d = shift_hdr;
				if ((shift_hdr & hdr_mask_q) == hdr_pattern_q) begin
					done_d    = 1'b0;
					ch_cnt_d  = 8'd0;
					bit_cnt_d = sfd_pkg::COUNT_BITS;
					phase_d   = sfd_pkg::PH_COUNT;
				end
			end
			sfd_pkg::PH_COUNT: begin
				queue_d   = shift_hdr;
				bit_cnt_d = bit_cnt_dec;
				if (bit_cnt_dec == 5'd0) begin
					cap_cnt_d = shift_hdr[7:0];
					queue_d   = shift_hdr >> sfd_pkg::COUNT_SHIFT;
					bit_cnt_d = sfd_pkg::SLOT_BITS;
					phase_d   = sfd_pkg::PH_DATA;
				end
			end
			sfd_pkg::PH_DATA: begin
				queue_d   = shift_slot;
				bit_cnt_d = bit_cnt_dec;
				if (bit_cnt_dec == 5'd0) begin
					emit      = 1'b1;
					bit_cnt_d = sfd_pkg::SLOT_BITS;
					queue_d   = slot_masked;
					ch_cnt_d  = ch_cnt_inc;
					// close the frame after the last slot
					if (ch_cnt_inc == ch_total_q) begin
						queue_d  = 32'd0;
						done_d   = 1'b1;
						phase_d  = sfd_pkg::PH_WAIT;
						res_last = 1'b1;
					end
				end
			end
			sfd_pkg::PH_WAIT: begin
				if (!done_d) begin
					phase_d = sfd_pkg::PH_HEADER;
				end
			end
			default: phase_d = sfd_pkg::PH_HEADER;
		endcase
	end

	// Advance state on every accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sfd_pkg::PH_HEADER;
			queue_q   <= 32'd0;
			bit_cnt_q <= 5'd0;
			ch_cnt_q  <= 8'd0;
			done_q    <= 1'b0;
			cap_cnt_q <= 8'd0;
		end else if (accept) begin
			phase_q   <= phase_d;
			queue_q   <= queue_d;
			bit_cnt_q <= bit_cnt_d;
			ch_cnt_q  <= ch_cnt_d;
			done_q    <= done_d;
			cap_cnt_q <= cap_cnt_d;
		end
	end

	// Output register: load a finished word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (channels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_index_q <= ch_cnt_q;
			out_value_q <= res_value;
			out_count_q <= cap_cnt_q;
			out_last_q  <= res_last;
		end
	end

	assign channels.valid             = out_valid_q;
	assign channels.channel_index     = out_index_q;
	assign channels.channel_value     = out_value_q;
	assign channels.frame_count_field = out_count_q;
	assign channels.last_channel      = out_last_q;

	// A pending word is never overwritten by a new one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !channels.ready) |-> !(accept && emit))
		else $error("channel word overwritten while stalled");

	// The last slot of a frame leaves the block waiting with done set
	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit && res_last) |=> (phase_q == sfd_pkg::PH_WAIT) && done_q)
		else $error("frame did not close after last channel");

	// The end of the count word opens the first slot
	a_count_to_data: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == sfd_pkg::PH_COUNT && bit_cnt_q == 5'd1)
		|=> (phase_q == sfd_pkg::PH_DATA) && (bit_cnt_q == sfd_pkg::SLOT_BITS))
		else $error("count word did not hand over to data phase");

	// Bit counter never sits at zero while counting bits
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sfd_pkg::PH_COUNT || phase_q == sfd_pkg::PH_DATA) |-> bit_cnt_q != 5'd0)
		else $error("bit counter reached zero inside a counting phase");

endmodule

// File: sim/sfd_checker.sv
`timescale 1ns / 100ps
// Checker of the serial frame deframer: watches the sample, word and APB channels,
// predicts every channel word and compares it. Depends on sfd_pkg and sfd_if.sv.
module sfd_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	sfd_bit_if                        samples,
	sfd_word_if                       channels,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [sfd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output int                        fail_count,
	output int                        pending
);

	typedef struct packed {
		logic [7:0]  idx;
		logic [15:0] value;
		logic [7:0]  count;
		logic        last;
	} word_t;

	// Register shadows
	logic [31:0] hdr_pattern;
	logic [31:0] hdr_mask;
	logic [7:0]  ch_total;

	// Deframer shadow state
	logic [31:0]     shift_q;
	logic [4:0]      bit_cnt;
	logic [7:0]      ch_cnt;
	sfd_pkg::phase_t frame_phase;
	logic            frame_done;
	logic [7:0]      cnt_byte;

	word_t expected_words[$];

	initial fail_count = 0;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: channel word mismatch on %s: got %0h, want %0h", $time, what, got, want);
		fail_count++;
	endtask

	// Advance the shadow deframer by one sample and queue the word it completes
	task automatic deframe_step(input logic b, input logic r);
		word_t      w;
		logic [7:0] low;
		if (r)
			frame_done = 1'b0;
		case (frame_phase)
			sfd_pkg::PH_HEADER: begin
				shift_q = {b, shift_q[31:1]};
				if ((shift_q & hdr_mask) == hdr_pattern) begin
					frame_done = 1'b0;
					ch_cnt = 8'd0;
					bit_cnt = sfd_pkg::COUNT_BITS;
					frame_phase = sfd_pkg::PH_COUNT;
				end
			end
			sfd_pkg::PH_COUNT: begin
				shift_q = {b, shift_q[31:1]};
				bit_cnt = bit_cnt - 5'd1;
				if (bit_cnt == 5'd0) begin
					cnt_byte = shift_q[7:0];
					shift_q = shift_q >> sfd_pkg::COUNT_SHIFT;
					bit_cnt = sfd_pkg::SLOT_BITS;
					frame_phase = sfd_pkg::PH_DATA;
				end
			end
			sfd_pkg::PH_DATA: begin
				shift_q = (shift_q >> 1) | (32'(b) << sfd_pkg::SLOT_TOP);
				bit_cnt = bit_cnt - 5'd1;
				if (bit_cnt == 5'd0) begin
					low = shift_q[7:0];
					bit_cnt = sfd_pkg::SLOT_BITS;
					shift_q = shift_q & sfd_pkg::HI_BYTE_MASK;
					w.value = 16'((shift_q >> 2) | {24'd0, low});
					w.idx = ch_cnt;
					w.count = cnt_byte;
					w.last = 1'b0;
					ch_cnt = ch_cnt + 8'd1;
					if (ch_cnt == ch_total) begin
						shift_q = 32'd0;
						frame_done = 1'b1;
						frame_phase = sfd_pkg::PH_WAIT;
						w.last = 1'b1;
					end
					expected_words.push_back(w);
				end
			end
			sfd_pkg::PH_WAIT: begin
				if (!frame_done)
					frame_phase = sfd_pkg::PH_HEADER;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			hdr_pattern = sfd_pkg::HDR_PATTERN_RST;
			hdr_mask = sfd_pkg::HDR_MASK_RST;
			ch_total = sfd_pkg::CH_TOTAL_RST;
			shift_q = 32'd0;
			bit_cnt = 5'd0;
			ch_cnt = 8'd0;
			frame_phase = sfd_pkg::PH_HEADER;
			frame_done = 1'b0;
			cnt_byte = 8'd0;
			expected_words.delete();
			pending = 0;
		end else begin
			// Compare each word transaction with the oldest prediction
			if (channels.valid && channels.ready) begin
				if (expected_words.size() == 0) begin
					flag_mismatch("unexpected word", 32'(channels.channel_value), 32'd0);
				end else begin
					w = expected_words.pop_front();
					if (channels.channel_index !== w.idx)
						flag_mismatch("channel_index", 32'(channels.channel_index), 32'(w.idx));
					if (channels.channel_value !== w.value)
						flag_mismatch("channel_value", 32'(channels.channel_value), 32'(w.value));
					if (channels.frame_count_field !== w.count)
						flag_mismatch("frame_count_field", 32'(channels.frame_count_field),
							32'(w.count));
					if (channels.last_channel !== w.last)
						flag_mismatch("last_channel", 32'(channels.last_channel), 32'(w.last));
				end
			end
			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[sfd_pkg::ADDR_W-1:2])
					sfd_pkg::REG_HDR_PATTERN: hdr_pattern = pwdata;
					sfd_pkg::REG_HDR_MASK:    hdr_mask = pwdata;
					sfd_pkg::REG_CH_TOTAL:    ch_total = pwdata[7:0];
					default: ;
				endcase
			end
			// Predict from each sample transaction
			if (samples.valid && samples.ready)
				deframe_step(samples.line_bit, samples.release_done);
			pending = expected_words.size();
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top of the serial frame deframer: clock, reset, sample and APB stimulus
// and the verdict. Depends on sfd_pkg, sfd_if.sv, the block and sim/sfd_checker.sv.
module tb_top;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [sfd_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	int                         n_fail;
	int                         n_pending;
	int                         items_sent;
	bit                         gaps_on;

	sfd_bit_if  samples_ch();
	sfd_word_if words_ch();

	serial_frame_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_ch),
		.channels (words_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	sfd_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples_ch),
		.channels   (words_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (n_fail),
		.pending    (n_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("FAIL serial_frame_deframer");
		$finish;
	end

	// Stall the word channel at random while gaps are on
	always @(negedge clk) begin
		if (gaps_on)
			words_ch.ready <= ($urandom_range(0, 99) >= 29);
		else
			words_ch.ready <= 1'b1;
	end

	function automatic logic noise_release();
		return ($urandom_range(0, 7) == 0);
	endfunction

	// Offer one sample transaction and hold it until accepted; enter and leave on a falling edge
	task automatic push_sample(input logic b, input logic r);
		while (gaps_on && $urandom_range(0, 99) < 29) begin
			samples_ch.valid <= 1'b0;
			@(negedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.line_bit <= b;
		samples_ch.release_done <= r;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted word has left
	task automatic wait_drained();
		samples_ch.valid <= 1'b0;
		@(negedge clk);
		while (n_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Noise, a header (broken now and then), count bits, channel slots, then release
	task automatic send_frame(input logic [31:0] pat, input logic [31:0] msk,
		input logic [7:0] total);
		int   n_ch;
		int   flip;
		logic b;
		n_ch = (total == 8'd0) ? 256 : int'(total);
		flip = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 31)) : -1;
		repeat ($urandom_range(0, 6)) push_sample(1'($urandom), noise_release());
		for (int i = 0; i < 32; i++) begin
			b = msk[i] ? pat[i] : 1'($urandom);
			if (i == flip)
				b = ~b;
			push_sample(b, noise_release());
		end
		repeat (30) push_sample(1'($urandom), noise_release());
		repeat (n_ch * 21) push_sample(1'($urandom), noise_release());
		repeat ($urandom_range(0, 3)) push_sample(1'($urandom), 1'b0);
		push_sample(1'($urandom), 1'b1);
	endtask

	task automatic run_phase(input logic [31:0] pat, input logic [31:0] msk,
		input logic [7:0] total, input int budget);
		int stop_at;
		wait_drained();
		write_reg(sfd_pkg::REG_HDR_PATTERN, pat);
		write_reg(sfd_pkg::REG_HDR_MASK, msk);
		write_reg(sfd_pkg::REG_CH_TOTAL, {24'd0, total});
		stop_at = items_sent + budget;
		while (items_sent < stop_at)
			send_frame(pat, msk, total);
	endtask

	initial begin
		logic [31:0] msk;
		items_sent = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		samples_ch.valid = 1'b0;
		samples_ch.line_bit = 1'b0;
		samples_ch.release_done = 1'b0;
		words_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset registers: an all-zero header matches on the first zero bit
		push_sample(1'b0, 1'b0);
		repeat (30) push_sample(1'b1, 1'b0);
		for (int i = 0; i < 20; i++)
			push_sample(i[0], 1'b0);
		// Release in the frame-ending step must not clear the new done flag
		push_sample(1'b1, 1'b1);
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b1);

		msk = $urandom;
		run_phase($urandom & msk, msk, 8'd3, 100);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 100);
		// Empty mask: every hunt step matches
		run_phase(32'd0, 32'd0, 8'd2, 100);
		run_phase($urandom & 32'h0000_FFFF, 32'h0000_FFFF, 8'd4, 100);
		// Pattern bit outside the mask: the header never matches
		run_phase(32'h8000_0100, 32'h0000_00FF, 8'd2, 100);
		// One long frame of many channels
		msk = $urandom;
		run_phase($urandom & msk, msk, 8'd12, 1);
		// Long stretch with no idling on either side
		gaps_on = 1'b0;
		msk = $urandom;
		run_phase($urandom & msk, msk, 8'($urandom_range(1, 8)), 300);
		gaps_on = 1'b1;
		run_phase(sfd_pkg::HDR_PATTERN_RST, sfd_pkg::HDR_MASK_RST, sfd_pkg::CH_TOTAL_RST, 100);

		wait_drained();
		repeat (8) @(negedge clk);
		if (n_fail == 0)
			$display("PASS serial_frame_deframer");
		else
			$display("FAIL serial_frame_deframer");
		$finish;
	end

endmodule
